// ===== rtl/core/srvb_pkg.sv =====
// Package for the reverb core: shared widths, register indexes, fixed sizes
// and MAC operation codes. No dependencies.
`default_nettype none
package srvb_pkg;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;
    localparam logic [CfgIdxW-1:0] REG_COMB_FB = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_DAMPING = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_AP_FB   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_WET     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_DELAY_A = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_DELAY_B = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_DELAY_C = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_DELAY_D = 3'd7;
    localparam int unsigned ApDelayEven = 207;
    localparam int unsigned ApDelayOdd = 22;
    localparam int unsigned MacW = 56;

    // Line length and comb count are fixed: line addressing packs the line
    // number above the position, and the comb average is a plain shift.
    localparam int unsigned DelayDepth = 2048;
    localparam int unsigned NumCombs = 4;

    // Operation codes for the shared multiply-accumulate unit.
    typedef enum logic [1:0] {
        MAC_CLR  = 2'd0,   // acc = a*b
        MAC_ADD  = 2'd1,   // acc = acc + a*b
        MAC_HOLD = 2'd2
    } t_mac_op;
endpackage
`default_nettype wire

// ===== rtl/core/srvb_mac.sv =====
// Shared signed multiply-accumulate unit for the reverb core.
// Uses srvb_pkg for the operation codes and accumulator width.
`default_nettype none
module srvb_mac (
    input  wire logic                          i_clk,
    input  wire srvb_pkg::t_mac_op             i_op,
    input  wire logic signed [33:0]            i_a,
    input  wire logic        [16:0]            i_b,
    output logic signed [srvb_pkg::MacW-1:0]   o_acc
);
    logic signed [51:0] prod;
    logic signed [srvb_pkg::MacW-1:0] r_acc;
    assign prod = 52'(i_a * $signed({1'b0, i_b}));
    always_ff @(posedge i_clk) begin
        case (i_op)
            srvb_pkg::MAC_CLR: r_acc <= srvb_pkg::MacW'(prod);
            srvb_pkg::MAC_ADD: r_acc <= r_acc + srvb_pkg::MacW'(prod);
            default: r_acc <= r_acc;
        endcase
    end
    assign o_acc = r_acc;
endmodule
`default_nettype wire

// ===== rtl/core/schroeder_reverb.sv =====
// Schroeder reverberator: parallel damped combs, series allpasses, wet/dry mix.
// A single shared multiply-accumulate unit (srvb_mac) does all multiplication
// under a small sequencer; all delay lines live in one memory here.
// Uses srvb_pkg.
//
// Each accepted sample passes the idle state for the handshake, then the
// comb, allpass and mix steps in turn, as set by the single MAC and the
// one-port delay memory that the sequencer steps through one read or write
// at a time; a new sample is accepted only back in the idle state. The
// result then waits in an output register; the next item is taken while it
// waits, and only the last mix step holds until the waiting result has been
// handed off.
// After reset a clearing pass walks every word of the delay memory, one
// word a cycle; no item is accepted during it.
// Configuration writes are taken at any time and are assumed to arrive
// only while the block is idle.
`default_nettype none
module schroeder_reverb #(
    parameter int unsigned INTERNAL_WIDTH = 20,
    parameter int unsigned NUM_ALLPASSES  = 2
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [srvb_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  wire logic [srvb_pkg::CfgDataW-1:0]     i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [15:0]                i_sample_in,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [15:0]                     o_sample_out,
    output logic                                   o_clipped
);
    localparam int unsigned DELAY_DEPTH = srvb_pkg::DelayDepth;
    localparam int unsigned NUM_COMBS   = srvb_pkg::NumCombs;
    localparam int unsigned PW   = $clog2(DELAY_DEPTH);
    localparam int unsigned NL   = NUM_COMBS + 2 * NUM_ALLPASSES;
    localparam int unsigned LW   = (NL > 1) ? $clog2(NL) : 1;
    localparam int unsigned MW   = LW + PW;
    localparam int unsigned MD   = NL * DELAY_DEPTH;
    localparam int unsigned IW   = INTERNAL_WIDTH;
    localparam int unsigned KW   = (NUM_COMBS > 1) ? $clog2(NUM_COMBS) : 1;
    localparam int unsigned AW   = (NUM_ALLPASSES > 1) ? $clog2(NUM_ALLPASSES) : 1;
    localparam int unsigned SW   = IW + 4;  // comb sum width
    localparam int unsigned DmW  = PW;       // delay used modulo depth
    localparam int unsigned MacW = srvb_pkg::MacW;

    // Sequencer states, one-hot.
    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_CRD    = 13'b0000000000100,  // issue comb tap read
        S_CWAIT  = 13'b0000000001000,  // memory data arrives
        S_CLP1   = 13'b0000000010000,  // acc = (65536-d)*y
        S_CLP2   = 13'b0000000100000,  // acc += d*lp
        S_CFB    = 13'b0000001000000,  // lp stored, acc = fb*lp
        S_CWR    = 13'b0000010000000,  // c computed, write, sum
        S_ARD    = 13'b0000100000000,  // read allpass input tap
        S_ARD2   = 13'b0001000000000,  // read output tap, xd arrives
        S_AMUL   = 13'b0010000000000,  // yd arrives, acc = g*(yd-u)
        S_AWR    = 13'b0100000000000,  // write u then v
        S_MIX    = 13'b1000000000000   // mix steps
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [15:0] r_comb_fb, r_damp, r_ap_fb, r_wet;
    logic [10:0] r_dly [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comb_fb <= 16'd12976;
            r_damp    <= 16'd13500;
            r_ap_fb   <= 16'd13107;
            r_wet     <= 16'd21627;
            r_dly[0]  <= 11'd1428;
            r_dly[1]  <= 11'd1486;
            r_dly[2]  <= 11'd1371;
            r_dly[3]  <= 11'd1305;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                srvb_pkg::REG_COMB_FB: r_comb_fb <= i_cfg_data;
                srvb_pkg::REG_DAMPING: r_damp    <= i_cfg_data;
                srvb_pkg::REG_AP_FB:   r_ap_fb   <= i_cfg_data;
                srvb_pkg::REG_WET:     r_wet     <= i_cfg_data;
                srvb_pkg::REG_DELAY_A: r_dly[0]  <= i_cfg_data[10:0];
                srvb_pkg::REG_DELAY_B: r_dly[1]  <= i_cfg_data[10:0];
                srvb_pkg::REG_DELAY_C: r_dly[2]  <= i_cfg_data[10:0];
                srvb_pkg::REG_DELAY_D: r_dly[3]  <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Delay memory: one line per comb, then per allpass an input line and
    // an output line. Single port, registered read.
    logic signed [IW-1:0] mem [MD];
    logic signed [IW-1:0] r_rdata;
    logic                 mem_we;
    logic [MW-1:0]        mem_addr;
    logic signed [IW-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        r_rdata <= mem[mem_addr];
    end

    // Datapath registers.
    logic [MW:0]            r_clr_cnt;
    logic [PW-1:0]          r_wpos;
    logic [KW-1:0]          r_k;
    logic [AW-1:0]          r_a;
    logic [1:0]             r_sub;
    logic signed [15:0]     r_x;
    logic signed [IW-1:0]   r_lp [NUM_COMBS];
    logic signed [IW-1:0]   r_y;      // comb tap
    logic signed [IW-1:0]   r_xd;
    logic signed [IW-1:0]   r_u;      // current stage input
    logic signed [IW-1:0]   r_v;
    logic signed [SW-1:0]   r_sum;
    logic                   r_out_valid;
    logic signed [15:0]     r_out;
    logic                   r_clip;

    // MAC controls.
    srvb_pkg::t_mac_op      mac_op;
    logic signed [33:0]     mac_a;
    logic        [16:0]     mac_b;
    logic signed [MacW-1:0] acc;

    srvb_mac u_mac (
        .i_clk (i_clk),
        .i_op  (mac_op),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_acc (acc)
    );

    // Saturate a wide value to the internal range.
    function automatic logic signed [IW-1:0] sat_i(input logic signed [MacW-1:0] v);
        logic signed [MacW-1:0] hi, lo;
        hi = MacW'((64'sd1 <<< (IW - 1)) - 64'sd1);
        lo = -hi - MacW'(1);
        if (v > hi) sat_i = IW'(hi);
        else if (v < lo) sat_i = IW'(lo);
        else sat_i = IW'(v);
    endfunction

    // Tap address on a line for a given delay.
    function automatic logic [PW-1:0] tap_pos(input logic [PW-1:0] wp,
                                              input logic [DmW-1:0] d);
        tap_pos = wp - d;
    endfunction

    logic [DmW-1:0] comb_d, ap_d;
    logic [PW-1:0]  comb_t, ap_t;
    logic [LW-1:0]  ap_in_line, ap_out_line;
    logic signed [MacW-1:0] acc_sh;    // floor(acc / 65536)
    logic signed [MacW-1:0] x_ext;
    logic signed [IW-1:0]   c_val, v_val;
    logic signed [MacW-1:0] ap_sum;

    assign comb_d = DmW'(r_dly[2'(r_k) & 2'd3]);
    assign ap_d   = r_a[0] ? DmW'(srvb_pkg::ApDelayOdd % DELAY_DEPTH)
                           : DmW'(srvb_pkg::ApDelayEven % DELAY_DEPTH);
    assign comb_t = tap_pos(r_wpos, comb_d);
    assign ap_t   = tap_pos(r_wpos, ap_d);
    assign ap_in_line  = LW'(NUM_COMBS + 2 * int'(r_a));
    assign ap_out_line = LW'(NUM_COMBS + 2 * int'(r_a) + 1);
    assign acc_sh = acc >>> 16;
    assign x_ext  = MacW'(r_x);
    assign c_val  = sat_i(x_ext + acc_sh);
    assign ap_sum = MacW'(r_xd) + acc_sh;
    assign v_val  = sat_i(ap_sum);

    logic last_comb, last_ap;
    assign last_comb = (int'(r_k) == NUM_COMBS - 1);
    assign last_ap   = (int'(r_a) == NUM_ALLPASSES - 1);

    logic signed [MacW-1:0] mix_hi, mix_lo, mix_v;
    assign mix_hi = MacW'(32767);
    assign mix_lo = -MacW'(32768);
    assign mix_v  = acc_sh;

    // Hold the last mix step while the previous result still waits.
    logic out_stall, mix_done;
    assign out_stall = r_out_valid && !i_ready;
    assign mix_done  = (r_state == S_MIX) && (r_sub == 2'd2) && !out_stall;

    // Ready whenever the sequencer is idle; a waiting result only holds
    // the final mix step of the next item.
    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out;
    assign o_clipped    = r_clip;

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        mac_op    = srvb_pkg::MAC_HOLD;
        mac_a     = '0;
        mac_b     = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = MW'(r_clr_cnt);
                if (r_clr_cnt == (MW+1)'(MD - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = S_CRD;
            end
            S_CRD: begin
                mem_addr = {LW'(r_k), comb_t};
                n_state  = S_CWAIT;
            end
            S_CWAIT: n_state = S_CLP1;
            S_CLP1: begin
                mac_op  = srvb_pkg::MAC_CLR;
                mac_a   = 34'(r_y);
                mac_b   = 17'h10000 - 17'(r_damp);
                n_state = S_CLP2;
            end
            S_CLP2: begin
                mac_op  = srvb_pkg::MAC_ADD;
                mac_a   = 34'(r_lp[r_k]);
                mac_b   = 17'(r_damp);
                n_state = S_CFB;
            end
            S_CFB: begin
                mac_op  = srvb_pkg::MAC_CLR;
                mac_a   = 34'(sat_i(acc_sh));
                mac_b   = 17'(r_comb_fb);
                n_state = S_CWR;
            end
            S_CWR: begin
                mem_we    = 1'b1;
                mem_addr  = {LW'(r_k), r_wpos};
                mem_wdata = c_val;
                n_state   = last_comb ? S_ARD : S_CRD;
            end
            S_ARD: begin
                mem_addr = {ap_in_line, ap_t};
                n_state  = S_ARD2;
            end
            S_ARD2: begin
                mem_addr = {ap_out_line, ap_t};
                n_state  = S_AMUL;
            end
            S_AMUL: begin
                // r_rdata holds yd this cycle
                mac_op  = srvb_pkg::MAC_CLR;
                mac_a   = 34'(r_rdata) - 34'(r_u);
                mac_b   = 17'(r_ap_fb);
                n_state = S_AWR;
            end
            S_AWR: begin
                mem_we = 1'b1;
                if (r_sub == 2'd0) begin
                    mem_addr  = {ap_in_line, r_wpos};
                    mem_wdata = r_u;
                end else begin
                    mem_addr  = {ap_out_line, r_wpos};
                    mem_wdata = r_v;
                    n_state   = last_ap ? S_MIX : S_ARD;
                end
            end
            S_MIX: begin
                if (r_sub == 2'd0) begin
                    mac_op = srvb_pkg::MAC_CLR;
                    mac_a  = 34'(r_x);
                    mac_b  = 17'h10000 - 17'(r_wet);
                end else if (r_sub == 2'd1) begin
                    mac_op = srvb_pkg::MAC_ADD;
                    mac_a  = 34'(r_u);
                    mac_b  = 17'(r_wet);
                end else begin
                    if (mix_done) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_wpos      <= '0;
            r_k         <= '0;
            r_a         <= '0;
            r_sub       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_COMBS; i++) r_lp[i] <= '0;
        end else begin
            r_state <= n_state;
            if (mix_done) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: r_clr_cnt <= r_clr_cnt + 1'b1;
                S_IDLE: begin
                    if (i_valid) begin
                        r_x   <= i_sample_in;
                        r_k   <= '0;
                        r_a   <= '0;
                        r_sum <= '0;
                        r_sub <= '0;
                    end
                end
                S_CRD: ;
                S_CWAIT: r_y <= r_rdata;
                S_CLP1: ;
                S_CLP2: ;
                S_CFB: r_lp[r_k] <= sat_i(acc_sh);
                S_CWR: begin
                    r_sum <= r_sum + SW'(c_val);
                    if (last_comb) r_u <= IW'(((r_sum + SW'(c_val)) >>> KW));
                    else r_k <= r_k + 1'b1;
                end
                S_ARD: ;
                S_ARD2: r_xd <= r_rdata;
                S_AMUL: r_sub <= '0;
                S_AWR: begin
                    if (r_sub == 2'd0) begin
                        r_v   <= v_val;
                        r_sub <= 2'd1;
                    end else begin
                        r_u   <= r_v;
                        r_sub <= '0;
                        if (!last_ap) r_a <= r_a + 1'b1;
                    end
                end
                S_MIX: begin
                    if (r_sub != 2'd2) begin
                        r_sub <= r_sub + 1'b1;
                    end else if (mix_done) begin
                        r_sub       <= '0;
                        r_clip      <= (mix_v > mix_hi) || (mix_v < mix_lo);
                        if (mix_v > mix_hi) r_out <= 16'sh7fff;
                        else if (mix_v < mix_lo) r_out <= -16'sh8000;
                        else r_out <= 16'(mix_v);
                        r_wpos <= (int'(r_wpos) == DELAY_DEPTH - 1) ? '0 : r_wpos + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
